[hdl/mibp_pkg.sv]
// ----------------------------------------------------------------------------
// mibp_pkg
// Shared types and constants for the masked-index bimodal predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package mibp_pkg;

    localparam int ADDR_W      = 32;  // branch address bits used for the index
    localparam int CFG_DATA_W  = 32;  // widest configuration register
    localparam int CFG_INDEX_W = 1;
    localparam int STATES_W    = 5;   // counter_states register width
    localparam int OUT_IDX_W   = 10;  // table_index field width on the result
    localparam int IN_TDATA_W  = 40;  // address + outcome, padded to bytes
    localparam int OUT_TDATA_W = 16;  // prediction, mispredict, index, padded

    localparam logic [ADDR_W-1:0]   MASK_RESET   = 32'h0000_000F;
    localparam logic [STATES_W-1:0] STATES_RESET = 5'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INDEX_MASK     = 1'b0,
        REG_COUNTER_STATES = 1'b1
    } t_reg_index;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

endpackage : mibp_pkg

`default_nettype wire

[hdl/mibp_gather.sv]
// ----------------------------------------------------------------------------
// mibp_gather
// Parallel bit extract of the masked address bits into a packed table index.
// ----------------------------------------------------------------------------
`default_nettype none

module mibp_gather
    import mibp_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_mask_we,
    input  wire logic [ADDR_W-1:0]     i_mask,
    input  wire logic [ADDR_W-1:0]     i_addr,
    output logic      [INDEX_BITS-1:0] o_index
);

    // One row per index bit: which address bit lands there.
    typedef logic [INDEX_BITS-1:0][ADDR_W-1:0] t_sel;

    // Each selected bit goes to the position given by the count of
    // selected bits below it; positions past the index width drop out.
    function automatic t_sel sel_matrix(input logic [ADDR_W-1:0] m);
        t_sel s;
        int   cnt;
        s = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            cnt = $countones(m & ~({ADDR_W{1'b1}} << b));
            for (int j = 0; j < INDEX_BITS; j++) begin
                s[j][b] = m[b] && (cnt == j);
            end
        end
        return s;
    endfunction

    t_sel r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= sel_matrix(MASK_RESET);
        end else if (i_mask_we) begin
            r_sel <= sel_matrix(i_mask);
        end
    end

    always_comb begin
        for (int j = 0; j < INDEX_BITS; j++) begin
            o_index[j] = |(i_addr & r_sel[j]);
        end
    end

endmodule : mibp_gather

`default_nettype wire

[hdl/masked_index_bimodal_predictor.sv]
// ----------------------------------------------------------------------------
// masked_index_bimodal_predictor
// Bimodal branch predictor: a table of saturating counters indexed by the
// address bits selected in a configurable mask, packed lowest first.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transfer when              | contents
//  ---------+-----+----------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid & tready     | branch address, taken outcome
//  m_axis   | out | m_axis_tvalid & tready     | prediction, mispredict, index
//  cfg      | in  | i_cfg_we                   | index_mask, counter_states
//
//  One branch per cycle sustained while the output accepts. From input
//  transfer to result a branch passes the counter memory read, then
//  update, write-back and the result register.
//  After reset the counter table is cleared one entry a cycle, all 2**INDEX_BITS
//  entries (1024 by default); no branch is taken meanwhile, config writes are.
//  A stalled output holds the update stage, which holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_index_bimodal_predictor
    import mibp_pkg::*;
#(
    parameter int INDEX_BITS   = 10,
    parameter int COUNTER_BITS = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // resolved branches
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] branch_address, [32] taken
    // predictions
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata    // [0] predicted_taken,
                                                        // [1] mispredicted, [11:2] table_index
);

    localparam int DEPTH = 2 ** INDEX_BITS;
    // state count width: holds 2**COUNTER_BITS and the 5-bit register
    localparam int NW    = (COUNTER_BITS + 1 > STATES_W) ? COUNTER_BITS + 1 : STATES_W;
    localparam logic [NW-1:0] MAX_STATES = NW'(2 ** COUNTER_BITS);
    localparam logic [NW-1:0] MIN_STATES = NW'(2);

    // ---------------- configuration ----------------
    logic [STATES_W-1:0] r_states;
    logic                mask_we;
    logic [NW-1:0]       n_eff;

    assign mask_we = i_cfg_we && (i_cfg_index == REG_INDEX_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states <= STATES_RESET;
        end else if (i_cfg_we && (i_cfg_index == REG_COUNTER_STATES)) begin
            r_states <= i_cfg_data[STATES_W-1:0];
        end
    end

    // clamp to [2, 2**COUNTER_BITS]
    always_comb begin
        if (NW'(r_states) < MIN_STATES) begin
            n_eff = MIN_STATES;
        end else if (NW'(r_states) > MAX_STATES) begin
            n_eff = MAX_STATES;
        end else begin
            n_eff = NW'(r_states);
        end
    end

    // ---------------- index extract ----------------
    logic [ADDR_W-1:0]     in_addr;
    logic                  in_taken;
    logic [INDEX_BITS-1:0] in_index;

    assign in_addr  = s_axis_tdata[ADDR_W-1:0];
    assign in_taken = s_axis_tdata[ADDR_W];

    mibp_gather #(
        .INDEX_BITS (INDEX_BITS)
    ) u_gather (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mask_we (mask_we),
        .i_mask    (i_cfg_data[ADDR_W-1:0]),
        .i_addr    (in_addr),
        .o_index   (in_index)
    );

    // ---------------- control ----------------
    t_state                  r_state, n_state;
    logic [INDEX_BITS-1:0]   r_clr_addr, n_clr_addr;

    logic                    r_s1_valid;
    logic [INDEX_BITS-1:0]   r_s1_idx;
    logic                    r_s1_taken;

    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    logic                    in_fire;
    logic                    s1_advance;

    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    logic [COUNTER_BITS-1:0] mem_wdata;
    logic [COUNTER_BITS-1:0] upd_cnt;

    assign s1_advance    = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == ST_RUN) && (!r_s1_valid || s1_advance);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // clear sweep after reset, then write-back from the update stage
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        mem_we     = 1'b0;
        mem_waddr  = r_s1_idx;
        mem_wdata  = upd_cnt;
        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {INDEX_BITS{1'b1}}) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                mem_we = s1_advance;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // ---------------- counter memory ----------------
    logic [COUNTER_BITS-1:0] mem [DEPTH];
    logic [COUNTER_BITS-1:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire) begin
            r_mem_q <= mem[in_index];
        end
    end

    // last write-back, forwarded to a read that raced it
    logic                    r_wr_valid;
    logic [INDEX_BITS-1:0]   r_wr_idx;
    logic [COUNTER_BITS-1:0] r_wr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else if (s1_advance) begin
            r_wr_valid <= 1'b1;
        end
        if (s1_advance) begin
            r_wr_idx <= r_s1_idx;
            r_wr_cnt <= upd_cnt;
        end
    end

    // ---------------- update stage ----------------
    logic [COUNTER_BITS-1:0]         cur_cnt;
    logic [NW:0]                     twice_cnt;
    logic                            pred;
    logic [OUT_IDX_W+INDEX_BITS-1:0] idx_ext;
    logic [OUT_IDX_W-1:0]            out_idx;
    logic [OUT_TDATA_W-1:0]          out_data;

    assign cur_cnt   = (r_wr_valid && (r_wr_idx == r_s1_idx)) ? r_wr_cnt : r_mem_q;
    assign twice_cnt = (NW + 1)'(cur_cnt) << 1;
    // taken when the counter sits in the upper half (midpoint of an odd
    // count predicts not taken)
    assign pred      = twice_cnt >= (NW + 1)'(n_eff);

    always_comb begin
        upd_cnt = cur_cnt;
        if (r_s1_taken) begin
            if (NW'(cur_cnt) < (n_eff - 1'b1)) begin
                upd_cnt = cur_cnt + 1'b1;
            end
        end else if (cur_cnt != '0) begin
            upd_cnt = cur_cnt - 1'b1;
        end
    end

    assign idx_ext  = {{OUT_IDX_W{1'b0}}, r_s1_idx};
    assign out_idx  = idx_ext[OUT_IDX_W-1:0];
    assign out_data = {{(OUT_TDATA_W - OUT_IDX_W - 2){1'b0}}, out_idx,
                       pred != r_s1_taken, pred};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
        if (in_fire) begin
            r_s1_idx   <= in_index;
            r_s1_taken <= in_taken;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_advance) begin
            r_out_data <= out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // the clear sweep owns the memory; no lookup may start under it
    a_no_read_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !in_fire)
        else $error("branch accepted during table clear");

    // an accepted branch is in the update stage on the next cycle
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted branch lost before update stage");

    // every write-back comes with a result in the output register
    a_update_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> (r_out_valid && (r_wr_idx == $past(r_s1_idx))))
        else $error("update without matching result");
`endif

endmodule : masked_index_bimodal_predictor

`default_nettype wire

[sim/masked_index_bimodal_predictor_tb.sv]
// ----------------------------------------------------------------------------
// masked_index_bimodal_predictor_tb
// Self-checking bench for the masked-index bimodal predictor. A queue-fed
// driver sends resolved branches in random bursts. A monitor checks every
// prediction against a local model of the counter table. The reconfiguration
// phases cover mask shapes and counter sizes, the out-of-range ones included.
// ----------------------------------------------------------------------------

module masked_index_bimodal_predictor_tb;
    import mibp_pkg::*;

    localparam int INDEX_BITS   = 10;
    localparam int CTR_BITS     = 4;
    localparam int TABLE_DEPTH  = 1 << INDEX_BITS;
    localparam int MAX_STATES   = 1 << CTR_BITS;
    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 20000;  // idle cycles before giving up
    localparam int HOLD_CYCLES  = 400;    // long output back-pressure stretch
    localparam int DRAIN_CYCLES = 8;      // pipeline is two deep; margin on top
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic              taken;
        logic [ADDR_W-1:0] addr;
    } t_branch;

    // same layout as m_axis_tdata[11:0]
    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        logic                 misp;
        logic                 pred;
    } t_prediction;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} t_rx_mode;
    typedef enum int {MASK_NONE, MASK_ALL, MASK_RANDOM, MASK_FIELD, MASK_SPARSE,
                      MASK_HIGH} t_mask_shape;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    masked_index_bimodal_predictor #(
        .INDEX_BITS  (INDEX_BITS),
        .COUNTER_BITS(CTR_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [31:0] branch_address, [32] taken
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)    // [0] predicted_taken, [1] mispredicted,
                                        // [11:2] table_index
    );

    // local copy of the block's state and registers
    logic [CTR_BITS-1:0]   ctr_table [TABLE_DEPTH];
    logic [ADDR_W-1:0]     cur_mask;
    logic [STATES_W-1:0]   cur_states;

    t_branch     branch_q [$];   // branches waiting to be sent
    t_prediction pred_q   [$];   // predictions still owed by the block

    int  errors       = 0;
    int  n_branches   = 0;
    int  n_checked    = 0;
    int  n_mispredict = 0;
    int  n_phases     = 0;
    int  idle_cycles  = 0;
    int  burst_left   = 1;
    int  gap_left     = 0;
    logic hold_req    = 1'b0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    // parallel bit extract: selected address bits packed lowest first,
    // anything past the index width wraps away
    function automatic logic [OUT_IDX_W-1:0] gather_index(logic [ADDR_W-1:0] addr,
                                                          logic [ADDR_W-1:0] sel);
        logic [ADDR_W-1:0] packed_bits;
        int                pos;
        packed_bits = '0;
        pos = 0;
        for (int b = 0; b < ADDR_W; b++) begin
            if (sel[b]) begin
                packed_bits[pos] = addr[b];
                pos++;
            end
        end
        return packed_bits[OUT_IDX_W-1:0];
    endfunction

    // prediction from the counter before the update, then train it
    function automatic t_prediction predict_and_train(logic [ADDR_W-1:0] addr,
                                                      logic taken);
        t_prediction p;
        int          n;
        int          c;
        logic [OUT_IDX_W-1:0] idx;
        n = int'(cur_states);
        if (n < 2)
            n = 2;
        if (n > MAX_STATES)
            n = MAX_STATES;
        idx    = gather_index(addr, cur_mask);
        c      = int'(ctr_table[idx]);
        p.pred = (2 * c >= n);  // odd count: midpoint says not taken
        p.misp = (p.pred != taken);
        p.idx  = idx;
        // a counter left above range by a smaller state count only moves down
        if (taken) begin
            if (c < n - 1)
                c++;
        end else if (c > 0) begin
            c--;
        end
        ctr_table[idx] = CTR_BITS'(c);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // input side: transfer bookkeeping at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                ctr_table[i] = '0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            pred_q.push_back(predict_and_train(s_axis_tdata[ADDR_W-1:0],
                                               s_axis_tdata[ADDR_W]));
            void'(branch_q.pop_front());
            n_branches++;
            // a burst only ends on a transfer, so tvalid never drops early
            if (burst_left <= 1) begin
                burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 24);
                gap_left   = $urandom_range(0, 6);
            end else begin
                burst_left--;
            end
        end else if (gap_left > 0) begin
            gap_left--;
        end
    end

    // driver: offers the head of the queue at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && gap_left == 0 && branch_q.size() != 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(IN_TDATA_W-ADDR_W-1){1'b0}}, branch_q[0].taken,
                              branch_q[0].addr};
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // output side: receiver stall pattern plus one long hold-off
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode   = RX_ALWAYS;
    int       mode_left = 0;
    int       hold_left = 0;
    int       rx_cycle  = 0;
    logic     hold_done = 1'b0;

    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (rx_mode)
                RX_ALWAYS:      m_axis_tready <= 1'b1;
                RX_COIN:        m_axis_tready <= ($urandom_range(0, 1) != 0);
                RX_MOSTLY:      m_axis_tready <= ($urandom_range(0, 9) != 0);
                default:        m_axis_tready <= (rx_cycle % 3 == 0);
            endcase
        end
    end

    task automatic report_mismatch(string what, int want, int got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // monitor: every result transfer against the oldest owed prediction
    always @(posedge i_clk) begin
        t_prediction want;
        t_prediction got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUT_IDX_W+1:0];
            if (pred_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got 0x%03h",
                         $time, got);
            end else begin
                want = pred_q.pop_front();
                n_checked++;
                if (got.misp)
                    n_mispredict++;
                if (got.pred != want.pred)
                    report_mismatch("predicted_taken", int'(want.pred), int'(got.pred));
                if (got.misp != want.misp)
                    report_mismatch("mispredicted", int'(want.misp), int'(got.misp));
                if (got.idx != want.idx)
                    report_mismatch("table_index", int'(want.idx), int'(got.idx));
            end
        end
    end

    // watchdog: counts cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pred_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    // registers are written only with nothing in flight
    task automatic write_reg(t_reg_index idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_INDEX_MASK:     cur_mask   = val;
            REG_COUNTER_STATES: cur_states = val[STATES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_branch(logic [ADDR_W-1:0] addr, logic taken);
        t_branch b;
        b.addr  = addr;
        b.taken = taken;
        branch_q.push_back(b);
    endtask

    task automatic wait_idle();
        while (branch_q.size() != 0 || pred_q.size() != 0)
            @(negedge i_clk);
        n_phases++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_mask();
        t_mask_shape       shape;
        int                w;
        logic [ADDR_W-1:0] m;
        shape = t_mask_shape'($urandom_range(0, 5));
        m = '0;
        case (shape)
            MASK_NONE:   m = '0;
            MASK_ALL:    m = '1;
            MASK_RANDOM: m = $urandom;
            MASK_FIELD: begin
                w = $urandom_range(1, 12);
                m = ((32'h1 << w) - 1) << $urandom_range(0, ADDR_W - w);
            end
            MASK_SPARSE: begin
                repeat ($urandom_range(1, 4))
                    m[$urandom_range(0, ADDR_W-1)] = 1'b1;
            end
            default:     m = $urandom & 32'hFFFF_0000;
        endcase
        return m;
    endfunction

    // state counts lean on the edges: below, at and above the legal range
    function automatic logic [STATES_W-1:0] pick_states();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd2;
            3:       return 5'd3;
            4:       return 5'd15;
            5:       return 5'd16;
            6:       return 5'd17;
            7:       return 5'd31;
            default: return STATES_W'($urandom_range(0, 31));
        endcase
    endfunction

    // a few hot branches with fixed bias so counters saturate, plus noise
    task automatic run_random_phase(int n_items);
        logic [ADDR_W-1:0] pool [8];
        int                bias [8];
        int                j;
        for (j = 0; j < 8; j++) begin
            pool[j] = $urandom;
            bias[j] = 25 * $urandom_range(0, 4);
        end
        repeat (n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                j = $urandom_range(0, 7);
                push_branch(pool[j], $urandom_range(1, 100) <= bias[j]);
            end else begin
                push_branch($urandom, ($urandom_range(0, 1) != 0));
            end
        end
    endtask

    initial begin
        int total_random;
        int phase_len;
        int phase_no;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_INDEX_MASK;
        i_cfg_data  = '0;
        cur_mask    = MASK_RESET;
        cur_states  = STATES_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 4-bit mask, two-state counters; block is still
        // clearing its table, so these also check the stall at startup
        push_branch(32'h0000_0000, 1'b1);
        push_branch(32'h0000_0010, 1'b1);
        push_branch(32'hFFFF_FFFF, 1'b0);
        push_branch(32'hFFFF_FFF0, 1'b0);
        wait_idle();

        // every address bit selected (index wraps), state count below range
        write_reg(REG_INDEX_MASK, 32'hFFFF_FFFF);
        write_reg(REG_COUNTER_STATES, 32'd0);
        push_branch(32'hFFFF_FFFF, 1'b1);
        push_branch(32'hFFFF_FFFF, 1'b1);
        push_branch(32'hAAAA_AAAA, 1'b0);
        push_branch(32'h0000_0000, 1'b1);
        wait_idle();

        // odd state count: the midpoint must predict not taken
        write_reg(REG_INDEX_MASK, 32'h8000_0001);
        write_reg(REG_COUNTER_STATES, 32'd3);
        repeat (3) push_branch(32'h8000_0001, 1'b1);
        wait_idle();

        // drive a counter to 4, then shrink the range under it
        write_reg(REG_INDEX_MASK, 32'h0000_0300);
        write_reg(REG_COUNTER_STATES, 32'd5);
        repeat (4) push_branch(32'h0000_0100, 1'b1);
        wait_idle();
        write_reg(REG_COUNTER_STATES, 32'd3);
        push_branch(32'h0000_0100, 1'b1);
        push_branch(32'h0000_0100, 1'b0);
        push_branch(32'h0000_0100, 1'b0);
        wait_idle();

        // random phases, the first few pinned to the extremes
        total_random = 0;
        phase_no     = 0;
        while (total_random < RANDOM_ITEMS) begin
            case (phase_no)
                0: begin
                    write_reg(REG_INDEX_MASK, 32'hFFFF_FFFF);
                    write_reg(REG_COUNTER_STATES, 32'd31);
                end
                1: begin
                    write_reg(REG_INDEX_MASK, 32'h0000_0000);
                    write_reg(REG_COUNTER_STATES, 32'd1);
                end
                2: begin
                    write_reg(REG_INDEX_MASK, 32'h0000_03FF);
                    write_reg(REG_COUNTER_STATES, 32'd16);
                end
                default: begin
                    write_reg(REG_INDEX_MASK, pick_mask());
                    write_reg(REG_COUNTER_STATES, pick_states());
                end
            endcase
            phase_len = $urandom_range(60, 180);
            // long output stall while the queue is full: input must back up
            if (phase_no == 2)
                hold_req = 1'b1;
            run_random_phase(phase_len);
            wait_idle();
            total_random += phase_len;
            phase_no++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d branches over %0d configuration phases, incl. long stall.",
                 n_branches, n_phases);
        $display("Checked %0d predictions, %0d mispredicted, %0d mismatches.",
                 n_checked, n_mispredict, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/mibp_pkg.sv
hdl/mibp_gather.sv
hdl/masked_index_bimodal_predictor.sv
sim/masked_index_bimodal_predictor_tb.sv
